// File: rtl/core/ptw_pkg.sv
// Shared types and constants for the two-level page table walker.
`default_nettype none
package ptw_pkg;

   localparam int DIR_ENTRIES   = 1024;
   localparam int TABLE_ENTRIES = 1024;
   localparam int IDX_W         = 10;
   localparam int OFS_W         = 12;
   localparam int FRAME_W       = 20;
   localparam int VA_W          = 32;
   localparam int ENTRY_W       = 32;
   localparam int DIR_SHIFT     = 22;
   localparam int TBL_SHIFT     = 12;

   localparam logic [OFS_W-1:0] FLAGS_RESET_PRESENT = 12'h003;
   localparam logic [OFS_W-1:0] FLAGS_RESET_ABSENT  = 12'h002;

   typedef enum logic [1:0] {
      MODE_TRANSLATE = 2'd0,
      MODE_MAP       = 2'd1,
      MODE_UNMAP     = 2'd2,
      MODE_SET_DIR   = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      ST_OK          = 2'd0,
      ST_DIR_ABSENT  = 2'd1,
      ST_PAGE_ABSENT = 2'd2,
      ST_RANGE       = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      S_CLEAR,
      S_IDLE,
      S_DIR,
      S_TBL
   } state_type;

   typedef struct packed {
      mode_type           mode;
      logic [VA_W-1:0]    virt_addr;
      logic [FRAME_W-1:0] frame;
      logic [OFS_W-1:0]   entry_flags;
   } req_type;

   typedef struct packed {
      logic [VA_W-1:0] phys_addr;
      status_type      status;
   } rsp_type;

endpackage
`default_nettype wire

// File: rtl/core/ptw_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
`default_nettype none
module ptw_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   assign rd_data = rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

endmodule
`default_nettype wire

// File: rtl/core/two_level_page_table_walker.sv
// Two-level page table walker: directory and page-table memories with a walk sequencer.
//
// Requests arrive on req_ (valid/ready) and each yields exactly one response
// on rsp_ (valid/ready), in order. A walk reads the directory memory in the
// accept cycle and the page-table memory in the cycle after, so a translate,
// map or unmap response is registered from S_TBL; a set directory request or
// a walk that fails at the directory answers from S_DIR. The next request is
// taken in the cycle a page-table walk finishes, never earlier (after an S_DIR
// answer the block goes idle first), bounded by the two dependent memory reads.
// Map, and unmap of a present page, write the page-table memory as the response
// is loaded. After reset a fill pass over all NUM_TABLES * 1024 page-table
// entries writes the directory and page-table reset contents, with req_ready low.
// The response sits in an output register; while rsp_ready is low a finished
// walk waits in place and takes no further request, though an idle block takes one.
`default_nettype none
module two_level_page_table_walker #(
   parameter int NUM_TABLES = 4
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire ptw_pkg::req_type req_payload,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output ptw_pkg::rsp_type      rsp_payload
);

   localparam int TBL_DEPTH = NUM_TABLES * ptw_pkg::TABLE_ENTRIES;
   localparam int TBL_AW    = $clog2(TBL_DEPTH);
   localparam int SLOT_W    = ptw_pkg::FRAME_W + ptw_pkg::IDX_W;

   ptw_pkg::state_type state_ff, state_in;
   logic [TBL_AW-1:0]  clr_ff, clr_in;
   ptw_pkg::req_type   req_ff, req_in;
   logic [TBL_AW-1:0]  slot_ff, slot_in;
   logic               rsp_valid_ff, rsp_valid_in;
   ptw_pkg::rsp_type   rsp_ff, rsp_in;

   logic                                dir_we, dir_re;
   logic [ptw_pkg::IDX_W-1:0]           dir_wa, dir_ra;
   logic [ptw_pkg::ENTRY_W-1:0]         dir_wd, dir_rd;
   logic                                tbl_we, tbl_re;
   logic [TBL_AW-1:0]                   tbl_wa, tbl_ra;
   logic [ptw_pkg::ENTRY_W-1:0]         tbl_wd, tbl_rd;

   logic                                out_free, accept;
   logic [ptw_pkg::IDX_W-1:0]           req_dir_idx;
   logic [ptw_pkg::FRAME_W-1:0]         dir_tbl;
   logic                                dir_present, dir_range_ok;
   logic [SLOT_W-1:0]                   slot_full;
   logic                                clr_low;

   ptw_ram #(.WIDTH(ptw_pkg::ENTRY_W), .DEPTH(ptw_pkg::DIR_ENTRIES)) u_dir_ram (
      .clock   (clock),
      .wr_en   (dir_we),
      .wr_addr (dir_wa),
      .wr_data (dir_wd),
      .rd_en   (dir_re),
      .rd_addr (dir_ra),
      .rd_data (dir_rd)
   );

   ptw_ram #(.WIDTH(ptw_pkg::ENTRY_W), .DEPTH(TBL_DEPTH)) u_tbl_ram (
      .clock   (clock),
      .wr_en   (tbl_we),
      .wr_addr (tbl_wa),
      .wr_data (tbl_wd),
      .rd_en   (tbl_re),
      .rd_addr (tbl_ra),
      .rd_data (tbl_rd)
   );

   assign out_free    = !rsp_valid_ff || rsp_ready;
   assign req_ready   = (state_ff == ptw_pkg::S_IDLE) ||
                        ((state_ff == ptw_pkg::S_TBL) && out_free);
   assign accept      = req_valid && req_ready;
   assign req_dir_idx = req_payload.virt_addr[ptw_pkg::DIR_SHIFT +: ptw_pkg::IDX_W];

   assign dir_tbl      = dir_rd[ptw_pkg::ENTRY_W-1:ptw_pkg::OFS_W];
   assign dir_present  = dir_rd[0];
   assign dir_range_ok = dir_tbl < ptw_pkg::FRAME_W'(NUM_TABLES);
   assign slot_full    = {dir_tbl,
                          req_ff.virt_addr[ptw_pkg::TBL_SHIFT +: ptw_pkg::IDX_W]};
   assign clr_low      = {1'b0, clr_ff} < (TBL_AW + 1)'(ptw_pkg::TABLE_ENTRIES);

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      req_in       = accept ? req_payload : req_ff;
      slot_in      = slot_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;

      dir_we = accept && (req_payload.mode == ptw_pkg::MODE_SET_DIR);
      dir_wa = req_dir_idx;
      dir_wd = {req_payload.frame, req_payload.entry_flags};
      dir_re = accept;
      dir_ra = req_dir_idx;

      tbl_we = 1'b0;
      tbl_wa = slot_ff;
      tbl_wd = '0;
      tbl_re = 1'b0;
      tbl_ra = slot_full[TBL_AW-1:0];

      case (state_ff)
         ptw_pkg::S_CLEAR: begin
            tbl_we = 1'b1;
            tbl_wa = clr_ff;
            tbl_wd = clr_low ?
                     {(ptw_pkg::FRAME_W - ptw_pkg::IDX_W)'(0), clr_ff[ptw_pkg::IDX_W-1:0],
                      ptw_pkg::FLAGS_RESET_PRESENT} : '0;
            dir_we = clr_low;
            dir_wa = clr_ff[ptw_pkg::IDX_W-1:0];
            dir_wd = (clr_ff == '0) ?
                     {ptw_pkg::FRAME_W'(0), ptw_pkg::FLAGS_RESET_PRESENT} :
                     {ptw_pkg::FRAME_W'(0), ptw_pkg::FLAGS_RESET_ABSENT};
            clr_in = clr_ff + TBL_AW'(1);
            if (clr_ff == TBL_AW'(TBL_DEPTH - 1)) begin
               state_in = ptw_pkg::S_IDLE;
            end
         end
         ptw_pkg::S_IDLE: begin
            if (accept) begin
               state_in = ptw_pkg::S_DIR;
            end
         end
         ptw_pkg::S_DIR: begin
            if ((req_ff.mode == ptw_pkg::MODE_SET_DIR) || !dir_present || !dir_range_ok) begin
               if (out_free) begin
                  rsp_valid_in = 1'b1;
                  rsp_in.phys_addr = '0;
                  if (req_ff.mode == ptw_pkg::MODE_SET_DIR) begin
                     rsp_in.status = ptw_pkg::ST_OK;
                  end else if (!dir_present) begin
                     rsp_in.status = ptw_pkg::ST_DIR_ABSENT;
                  end else begin
                     rsp_in.status = ptw_pkg::ST_RANGE;
                  end
                  state_in = ptw_pkg::S_IDLE;
               end
            end else begin
               tbl_re   = 1'b1;
               slot_in  = slot_full[TBL_AW-1:0];
               state_in = ptw_pkg::S_TBL;
            end
         end
         ptw_pkg::S_TBL: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_in.phys_addr = '0;
               rsp_in.status = ptw_pkg::ST_OK;
               if (req_ff.mode == ptw_pkg::MODE_MAP) begin
                  tbl_we = 1'b1;
                  tbl_wd = {req_ff.frame, (ptw_pkg::OFS_W - 1)'(0), req_ff.entry_flags[0]};
               end else if (!tbl_rd[0]) begin
                  rsp_in.status = ptw_pkg::ST_PAGE_ABSENT;
               end else if (req_ff.mode == ptw_pkg::MODE_TRANSLATE) begin
                  rsp_in.phys_addr = {tbl_rd[ptw_pkg::ENTRY_W-1:ptw_pkg::OFS_W],
                                      req_ff.virt_addr[ptw_pkg::OFS_W-1:0]};
               end else begin
                  tbl_we = 1'b1;
                  tbl_wd = {tbl_rd[ptw_pkg::ENTRY_W-1:1], 1'b0};
               end
               state_in = accept ? ptw_pkg::S_DIR : ptw_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = ptw_pkg::S_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ptw_pkg::S_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff  <= req_in;
      slot_ff <= slot_in;
      rsp_ff  <= rsp_in;
   end

endmodule
`default_nettype wire
